[rtl/akpe_pkg.sv]
// ----------------------------------------------------------------------------
// akpe_pkg
// shared types, constants and the cordic angle table of the arcsine kernel
// ----------------------------------------------------------------------------
package akpe_pkg;

   localparam int ACC_W   = 40;
   localparam int CFG_W   = 24;
   localparam int KERN_W  = 32;

   // configuration register indexes
   localparam logic [1:0] REG_WEIGHT = 2'd0;
   localparam logic [1:0] REG_BIAS   = 2'd1;
   localparam logic [1:0] REG_VAR    = 2'd2;

   localparam logic [CFG_W-1:0] CFG_ONE = 24'd65536;

   // pair queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam logic [QCNT_W-1:0] QUEUE_FULL = 3'd4;

   localparam logic [24:0] HALF_PI_Q24 = 25'd26353589;
   localparam logic [30:0] A_ONE       = 31'h40000000;

   typedef struct packed {
      logic signed [ACC_W-1:0] dot;
      logic [ACC_W-1:0]        norm_x;
      logic [ACC_W-1:0]        norm_y;
      logic                    sat;
   } pair_type;

   typedef struct packed {
      logic              valid;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_NUM,
      ST_DEN_A,
      ST_DEN_B,
      ST_SHIFT,
      ST_ROOT_S,
      ST_CMP,
      ST_DIV,
      ST_ROOT_X,
      ST_CSET,
      ST_CORDIC,
      ST_KERN
   } state_type;

   // atan(2^-i) in q.24 for the first steps, 2^(24-i) after
   function automatic logic [24:0] cordic_angle(input logic [4:0] i);
      logic [24:0] r;
      case (i)
         5'd0:    r = 25'd13176795;
         5'd1:    r = 25'd7778716;
         5'd2:    r = 25'd4110060;
         5'd3:    r = 25'd2086331;
         5'd4:    r = 25'd1047214;
         5'd5:    r = 25'd524117;
         5'd6:    r = 25'd262123;
         5'd7:    r = 25'd131069;
         default: r = 25'd1 << (5'd24 - i);
      endcase
      return r;
   endfunction

endpackage

[rtl/akpe_front.sv]
// ----------------------------------------------------------------------------
// akpe_front
// streaming accumulator: products per word, saturating sums, pair hand-off
// ----------------------------------------------------------------------------
module akpe_front #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_x_component,
   input  logic signed [COMPONENT_WIDTH-1:0] req_y_component,
   input  logic                              req_last_component,
   input  akpe_pkg::qstat_type               qstat,
   output logic                              push_valid,
   output akpe_pkg::pair_type                push_data
);

   localparam int PW    = 2 * COMPONENT_WIDTH;
   localparam int SUM_W = (PW + 2 > 42) ? PW + 2 : 42;
   localparam int AW    = akpe_pkg::ACC_W;

   logic                 s1_valid_ff;
   logic                 s1_last_ff;
   logic signed [PW-1:0] s1_xy_ff, s1_xx_ff, s1_yy_ff;

   logic signed [AW-1:0] dot_ff, dot_in;
   logic [AW-1:0]        nx_ff, nx_in, ny_ff, ny_in;
   logic                 sat_ff, sat_in;

   logic [SUM_W-1:0]     d_sum, p_sum, q_sum;
   logic                 d_ovf, p_ovf, q_ovf;
   logic [SUM_W-AW:0]    d_top;
   logic                 req_fire;

   assign req_fire  = req_valid && req_ready;
   // one last word may still sit in the product stage
   assign req_ready = ({1'b0, qstat.count} + {{akpe_pkg::QCNT_W{1'b0}}, s1_valid_ff && s1_last_ff})
                      < (akpe_pkg::QCNT_W + 1)'(akpe_pkg::QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s1_last_ff <= req_last_component;
         s1_xy_ff   <= req_x_component * req_y_component;
         s1_xx_ff   <= req_x_component * req_x_component;
         s1_yy_ff   <= req_y_component * req_y_component;
      end
   end

   always_comb begin
      d_sum = {{(SUM_W-AW){dot_ff[AW-1]}}, dot_ff} + {{(SUM_W-PW){s1_xy_ff[PW-1]}}, s1_xy_ff};
      p_sum = {{(SUM_W-AW){1'b0}}, nx_ff} + {{(SUM_W-PW){1'b0}}, s1_xx_ff};
      q_sum = {{(SUM_W-AW){1'b0}}, ny_ff} + {{(SUM_W-PW){1'b0}}, s1_yy_ff};
      d_top = d_sum[SUM_W-1:AW-1];
      d_ovf = !((&d_top) || !(|d_top));
      p_ovf = |p_sum[SUM_W-1:AW];
      q_ovf = |q_sum[SUM_W-1:AW];

      if (d_ovf) begin
         dot_in = d_sum[SUM_W-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         dot_in = d_sum[AW-1:0];
      end
      nx_in  = p_ovf ? {AW{1'b1}} : p_sum[AW-1:0];
      ny_in  = q_ovf ? {AW{1'b1}} : q_sum[AW-1:0];
      sat_in = sat_ff || d_ovf || p_ovf || q_ovf;

      push_valid       = s1_valid_ff && s1_last_ff;
      push_data.dot    = dot_in;
      push_data.norm_x = nx_in;
      push_data.norm_y = ny_in;
      push_data.sat    = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         nx_ff  <= '0;
         ny_ff  <= '0;
         sat_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         if (s1_last_ff) begin
            dot_ff <= '0;
            nx_ff  <= '0;
            ny_ff  <= '0;
            sat_ff <= 1'b0;
         end else begin
            dot_ff <= dot_in;
            nx_ff  <= nx_in;
            ny_ff  <= ny_in;
            sat_ff <= sat_in;
         end
      end
   end

endmodule

[rtl/akpe_queue.sv]
// ----------------------------------------------------------------------------
// akpe_queue
// short fifo of finished pair sums between the front and back ends
// ----------------------------------------------------------------------------
module akpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  akpe_pkg::pair_type  push_data,
   input  logic                pop,
   output akpe_pkg::qstat_type qstat,
   output akpe_pkg::pair_type  pop_data
);

   akpe_pkg::pair_type               entries_ff [akpe_pkg::QUEUE_DEPTH];
   logic [akpe_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [akpe_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_pop;

   assign do_pop      = pop && (count_ff != '0);
   assign qstat.valid = (count_ff != '0);
   assign qstat.count = count_ff;
   assign pop_data    = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != akpe_pkg::QUEUE_FULL || do_pop))
      else $error("pair pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= akpe_pkg::QUEUE_FULL)
      else $error("queue count out of range");
`endif

endmodule

[rtl/akpe_back.sv]
// ----------------------------------------------------------------------------
// akpe_back
// per-pair evaluation: shift-add multiplier, root, divider and cordic
// ----------------------------------------------------------------------------
module akpe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  akpe_pkg::qstat_type      qstat,
   input  akpe_pkg::pair_type       pair_data,
   output logic                     pair_pop,
   input  logic [23:0]              weight_scale,
   input  logic [23:0]              bias_offset,
   input  logic [23:0]              output_variance,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_kernel_value,
   output logic                     rsp_arg_clamped,
   output logic                     rsp_acc_saturated
);

   akpe_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [4:0]          cnt_ff, cnt_in;
   akpe_pkg::pair_type  pair_ff, pair_in;

   logic [63:0]         mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [31:0]         mul_b_ff, mul_b_in;
   logic [63:0]         sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic                neg_ff, neg_in;
   logic [47:0]         nmag_ff, nmag_in, n_ff, n_in;
   logic [48:0]         den_a_ff, den_a_in, den_b_ff, den_b_in;
   logic [31:0]         s_ff, s_in, rem_ff, rem_in;
   logic [29:0]         quo_ff, quo_in;
   logic [30:0]         a_ff, a_in;
   logic                clamp_ff, clamp_in;
   logic signed [33:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [27:0]  cz_ff, cz_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  kern_ff;
   logic                clamp_out_ff, sat_out_ff;
   logic                out_load;
   logic signed [31:0]  kern_val;

   logic [63:0]         mul_sum, sq_t, sq_v_next, sq_r_next;
   logic                sq_ge, div_ge, sha, shb;
   logic [32:0]         rem2;
   logic [31:0]         rem_next;
   logic [29:0]         quo_next;
   logic [39:0]         dmag;
   logic signed [49:0]  numv;
   logic signed [33:0]  cdx, cdy;
   logic signed [27:0]  cstep, cz_next;
   logic [24:0]         angle, mag;

   assign mul_sum   = mul_p_ff + (mul_b_ff[0] ? mul_a_ff : 64'd0);
   assign sq_t      = sq_r_ff + sq_bit_ff;
   assign sq_ge     = sq_v_ff >= sq_t;
   assign sq_v_next = sq_ge ? sq_v_ff - sq_t : sq_v_ff;
   assign sq_r_next = sq_ge ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;
   assign rem2      = {rem_ff, 1'b0};
   assign div_ge    = rem2 >= {1'b0, s_ff};
   assign rem_next  = div_ge ? 32'(rem2 - {1'b0, s_ff}) : rem2[31:0];
   assign quo_next  = {quo_ff[28:0], div_ge};
   assign cdx       = cy_ff >>> cnt_ff;
   assign cdy       = cx_ff >>> cnt_ff;
   assign cstep     = $signed({3'b0, akpe_pkg::cordic_angle(cnt_ff)});
   assign sha       = |den_a_ff[48:32];
   assign shb       = |den_b_ff[48:32];
   assign dmag      = pair_data.dot[39] ? 40'(-pair_data.dot) : pair_data.dot;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kernel_value  = kern_ff;
   assign rsp_arg_clamped   = clamp_out_ff;
   assign rsp_acc_saturated = sat_out_ff;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cnt_in    = cnt_ff;
      pair_in   = pair_ff;
      mul_a_in  = mul_a_ff;
      mul_b_in  = mul_b_ff;
      mul_p_in  = mul_p_ff;
      sq_v_in   = sq_v_ff;
      sq_r_in   = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      neg_in    = neg_ff;
      nmag_in   = nmag_ff;
      n_in      = n_ff;
      den_a_in  = den_a_ff;
      den_b_in  = den_b_ff;
      s_in      = s_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      a_in      = a_ff;
      clamp_in  = clamp_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      pair_pop  = 1'b0;
      out_load  = 1'b0;
      numv      = '0;
      cz_next   = cz_ff;
      angle     = '0;
      mag       = mul_p_ff[48:24];
      kern_val  = '0;

      case (state_ff)
         akpe_pkg::ST_IDLE: begin
            if (qstat.valid) begin
               pair_pop = 1'b1;
               pair_in  = pair_data;
               clamp_in = 1'b0;
               mul_a_in = {24'd0, dmag};
               mul_b_in = {8'd0, weight_scale};
               mul_p_in = '0;
               cnt_in   = '0;
               ret_in   = akpe_pkg::ST_NUM;
               state_in = akpe_pkg::ST_MUL;
            end
         end
         akpe_pkg::ST_MUL: begin
            mul_p_in = mul_sum;
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ret_ff;
            end
         end
         akpe_pkg::ST_SQRT: begin
            sq_v_in   = sq_v_next;
            sq_r_in   = sq_r_next;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ret_ff;
            end
         end
         akpe_pkg::ST_NUM: begin
            // signed numerator w*dot + b, then sign and magnitude
            numv = (pair_ff.dot[39] ? -$signed({3'b0, mul_p_ff[62:16]})
                                    : $signed({3'b0, mul_p_ff[62:16]}))
                   + $signed({18'd0, bias_offset, 8'd0});
            neg_in   = numv[49];
            nmag_in  = numv[49] ? 48'(-numv) : numv[47:0];
            mul_a_in = {24'd0, pair_ff.norm_x};
            mul_b_in = {8'd0, weight_scale};
            mul_p_in = '0;
            ret_in   = akpe_pkg::ST_DEN_A;
            state_in = akpe_pkg::ST_MUL;
         end
         akpe_pkg::ST_DEN_A: begin
            den_a_in = {1'b0, mul_p_ff[63:16]} + {17'd0, bias_offset, 8'd0} + 49'h1000000;
            mul_a_in = {24'd0, pair_ff.norm_y};
            mul_b_in = {8'd0, weight_scale};
            mul_p_in = '0;
            ret_in   = akpe_pkg::ST_DEN_B;
            state_in = akpe_pkg::ST_MUL;
         end
         akpe_pkg::ST_DEN_B: begin
            den_b_in = {1'b0, mul_p_ff[63:16]} + {17'd0, bias_offset, 8'd0} + 49'h1000000;
            n_in     = nmag_ff;
            state_in = akpe_pkg::ST_SHIFT;
         end
         akpe_pkg::ST_SHIFT: begin
            // even shifts bring each factor below 2^32; n drops by half the sum
            if (sha || shb) begin
               den_a_in = sha ? den_a_ff >> 2 : den_a_ff;
               den_b_in = shb ? den_b_ff >> 2 : den_b_ff;
               n_in     = (sha && shb) ? n_ff >> 2 : n_ff >> 1;
            end else begin
               mul_a_in = {32'd0, den_a_ff[31:0]};
               mul_b_in = den_b_ff[31:0];
               mul_p_in = '0;
               ret_in   = akpe_pkg::ST_ROOT_S;
               state_in = akpe_pkg::ST_MUL;
            end
         end
         akpe_pkg::ST_ROOT_S: begin
            sq_v_in   = mul_p_ff;
            sq_r_in   = '0;
            sq_bit_in = 64'h4000000000000000;
            ret_in    = akpe_pkg::ST_CMP;
            state_in  = akpe_pkg::ST_SQRT;
         end
         akpe_pkg::ST_CMP: begin
            s_in = sq_r_ff[31:0];
            if (n_ff < {16'd0, sq_r_ff[31:0]}) begin
               rem_in   = n_ff[31:0];
               quo_in   = '0;
               state_in = akpe_pkg::ST_DIV;
            end else begin
               clamp_in = n_ff > {16'd0, sq_r_ff[31:0]};
               a_in     = akpe_pkg::A_ONE;
               mul_a_in = {33'd0, akpe_pkg::A_ONE};
               mul_b_in = {1'b0, akpe_pkg::A_ONE};
               mul_p_in = '0;
               ret_in   = akpe_pkg::ST_ROOT_X;
               state_in = akpe_pkg::ST_MUL;
            end
         end
         akpe_pkg::ST_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd29) begin
               cnt_in   = '0;
               a_in     = {1'b0, quo_next};
               mul_p_in = '0;
               state_in = akpe_pkg::ST_MUL;
               if (quo_next == '0) begin
                  // zero argument, zero angle
                  mul_a_in = '0;
                  mul_b_in = {8'd0, output_variance};
                  ret_in   = akpe_pkg::ST_KERN;
               end else begin
                  mul_a_in = {34'd0, quo_next};
                  mul_b_in = {2'd0, quo_next};
                  ret_in   = akpe_pkg::ST_ROOT_X;
               end
            end
         end
         akpe_pkg::ST_ROOT_X: begin
            sq_v_in   = 64'h1000000000000000 - mul_p_ff;
            sq_r_in   = '0;
            sq_bit_in = 64'h4000000000000000;
            ret_in    = akpe_pkg::ST_CSET;
            state_in  = akpe_pkg::ST_SQRT;
         end
         akpe_pkg::ST_CSET: begin
            cx_in    = $signed({2'b0, sq_r_ff[31:0]});
            cy_in    = $signed({3'b0, a_ff});
            cz_in    = '0;
            state_in = akpe_pkg::ST_CORDIC;
         end
         akpe_pkg::ST_CORDIC: begin
            if (cy_ff > 34'sd0) begin
               cx_in   = cx_ff + cdx;
               cy_in   = cy_ff - cdy;
               cz_next = cz_ff + cstep;
            end else begin
               cx_in   = cx_ff - cdx;
               cy_in   = cy_ff + cdy;
               cz_next = cz_ff - cstep;
            end
            cz_in  = cz_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               if (cz_next < 28'sd0) begin
                  angle = '0;
               end else if (cz_next > $signed({3'b0, akpe_pkg::HALF_PI_Q24})) begin
                  angle = akpe_pkg::HALF_PI_Q24;
               end else begin
                  angle = cz_next[24:0];
               end
               cnt_in   = '0;
               mul_a_in = {39'd0, angle};
               mul_b_in = {8'd0, output_variance};
               mul_p_in = '0;
               ret_in   = akpe_pkg::ST_KERN;
               state_in = akpe_pkg::ST_MUL;
            end
         end
         akpe_pkg::ST_KERN: begin
            mag = 25'((mul_p_ff + 64'h800000) >> 24);
            if (nmag_ff == '0) begin
               kern_val = '0;
            end else if (neg_ff) begin
               kern_val = -$signed({7'd0, mag});
            end else begin
               kern_val = $signed({7'd0, mag});
            end
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = akpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = akpe_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= akpe_pkg::ST_IDLE;
         ret_ff       <= akpe_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff   <= pair_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      mul_p_ff  <= mul_p_in;
      sq_v_ff   <= sq_v_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      neg_ff    <= neg_in;
      nmag_ff   <= nmag_in;
      n_ff      <= n_in;
      den_a_ff  <= den_a_in;
      den_b_ff  <= den_b_in;
      s_ff      <= s_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      a_ff      <= a_in;
      clamp_ff  <= clamp_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      if (out_load) begin
         kern_ff      <= kern_val;
         clamp_out_ff <= clamp_ff;
         sat_out_ff   <= pair_ff.sat;
      end
   end

`ifndef ASSERT_OFF
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == akpe_pkg::ST_DIV) |-> (rem_ff < s_ff))
      else $error("divider remainder not below divisor");

   a_arg_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == akpe_pkg::ST_CORDIC) |-> (a_ff <= akpe_pkg::A_ONE && a_ff != '0))
      else $error("cordic argument outside (0, 1]");
`endif

endmodule

[rtl/arcsine_kernel_pair_eval.sv]
// ----------------------------------------------------------------------------
// arcsine_kernel_pair_eval: arcsine covariance of one pair of points
// throughput: one coordinate word per cycle while the pair queue has room;
// back end: one pair at a time, the next popped only in idle; clamped pairs skip the divide
// time from last word to result depends on the shift-add multiply,
// the bit-serial root and divide and the even shifts; reset is synchronous
// ----------------------------------------------------------------------------
module arcsine_kernel_pair_eval #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // coordinate words in
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0] req_x_component,
   input  logic signed [COMPONENT_WIDTH-1:0] req_y_component,
   input  logic                              req_last_component,
   // kernel results out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_kernel_value,
   output logic                              rsp_arg_clamped,
   output logic                              rsp_acc_saturated,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [23:0]                       csr_data
);

   // configuration registers, q8.16, reset to one
   logic [23:0] weight_ff, bias_ff, var_ff;

   akpe_pkg::pair_type  push_data, pop_data;
   akpe_pkg::qstat_type qstat;
   logic                push_valid;
   logic                pair_pop;

   // writes are always taken and land in the next cycle; unknown index is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= akpe_pkg::CFG_ONE;
         bias_ff   <= akpe_pkg::CFG_ONE;
         var_ff    <= akpe_pkg::CFG_ONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            akpe_pkg::REG_WEIGHT: weight_ff <= csr_data;
            akpe_pkg::REG_BIAS:   bias_ff   <= csr_data;
            akpe_pkg::REG_VAR:    var_ff    <= csr_data;
            default:              ;
         endcase
      end
   end

   // front end: word products, saturating sums, push on the last word
   akpe_front #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_component    (req_x_component),
      .req_y_component    (req_y_component),
      .req_last_component (req_last_component),
      .qstat              (qstat),
      .push_valid         (push_valid),
      .push_data          (push_data)
   );

   // finished pair sums wait here so the stream stalls on the back end only when the queue is full
   akpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pair_pop),
      .qstat      (qstat),
      .pop_data   (pop_data)
   );

   // back end: numerator, denominator root, divide, cordic arcsine, scale
   akpe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .pair_data         (pop_data),
      .pair_pop          (pair_pop),
      .weight_scale      (weight_ff),
      .bias_offset       (bias_ff),
      .output_variance   (var_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kernel_value  (rsp_kernel_value),
      .rsp_arg_clamped   (rsp_arg_clamped),
      .rsp_acc_saturated (rsp_acc_saturated)
   );

endmodule

[dv/arcsine_kernel_pair_eval_tb.sv]
// ----------------------------------------------------------------------------
// arcsine_kernel_pair_eval_tb
// Streams coordinate pairs into the arcsine kernel and checks every kernel
// result against a bit-true prediction kept in a small scoreboard class.
// Runs through several register settings and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arcsine_kernel_pair_eval_tb;

   // index past the register map, the block drops the write
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [23:0] CFG_MAX = 24'hFFFFFF;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [31:0] kernel;
      logic        clamped;
      logic        saturated;
   } kernel_result_type;

   // prediction of the kernel and queue of results still to come
   class kernel_scoreboard;
      longint unsigned weight_scale = 65536;
      longint unsigned bias_offset = 65536;
      longint unsigned out_variance = 65536;
      longint          dot_sum;
      longint unsigned norm_x_sum;
      longint unsigned norm_y_sum;
      bit              sat_seen;
      kernel_result_type pending_kernels[$];
      int              errors;
      longint          atan_tab[8] = '{13176795, 7778716, 4110060, 2086331,
                                       1047214, 524117, 262123, 131069};

      function void write_reg(logic [1:0] idx, logic [23:0] data);
         case (idx)
            akpe_pkg::REG_WEIGHT: weight_scale = data;
            akpe_pkg::REG_BIAS:   bias_offset = data;
            akpe_pkg::REG_VAR:    out_variance = data;
            default:    ;
         endcase
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function int even_shift(longint unsigned v);
         int s;
         s = 0;
         while ((v >> s) >= (64'd1 << 32)) s += 2;
         return s;
      endfunction

      function void note_word(logic signed [15:0] xc, logic signed [15:0] yc, logic last);
         longint xv, yv, d, num, cx, cy, z, stp, dx, dy;
         longint unsigned p, q, dmag, nmag, den_a, den_b, s, n, a, mag;
         int sa, sb, h;
         bit neg, clamped;
         kernel_result_type r;
         xv = xc;
         yv = yc;
         d = dot_sum + xv * yv;
         p = norm_x_sum + longint'(xv * xv);
         q = norm_y_sum + longint'(yv * yv);
         if (d > 64'sd549755813887) begin d = 64'sd549755813887; sat_seen = 1; end
         if (d < -64'sd549755813888) begin d = -64'sd549755813888; sat_seen = 1; end
         if (p > 64'd1099511627775) begin p = 64'd1099511627775; sat_seen = 1; end
         if (q > 64'd1099511627775) begin q = 64'd1099511627775; sat_seen = 1; end
         dot_sum = d;
         norm_x_sum = p;
         norm_y_sum = q;
         if (!last) return;

         dmag = (d < 0) ? longint'(-d) : longint'(d);
         dmag = (dmag * weight_scale) >> 16;
         num = ((d < 0) ? -longint'(dmag) : longint'(dmag)) + longint'(bias_offset << 8);
         neg = num < 0;
         nmag = neg ? longint'(-num) : longint'(num);
         den_a = ((p * weight_scale) >> 16) + (bias_offset << 8) + (64'd1 << 24);
         den_b = ((q * weight_scale) >> 16) + (bias_offset << 8) + (64'd1 << 24);
         sa = even_shift(den_a);
         sb = even_shift(den_b);
         h = (sa + sb) / 2;
         s = isqrt((den_a >> sa) * (den_b >> sb));
         n = nmag >> h;
         clamped = 0;
         if (n < s) begin
            a = (n << 30) / s;
         end else begin
            a = 64'd1 << 30;
            clamped = n > s;
         end

         // cordic vectoring, angle of (sqrt(1-a^2), a) in q.24
         z = 0;
         if (a != 0) begin
            cx = isqrt((64'd1 << 60) - a * a);
            cy = a;
            for (int i = 0; i < 24; i++) begin
               stp = (i < 8) ? atan_tab[i] : (64'sd1 << (24 - i));
               dx = cy >>> i;
               dy = cx >>> i;
               if (cy > 0) begin
                  cx += dx; cy -= dy; z += stp;
               end else begin
                  cx -= dx; cy += dy; z -= stp;
               end
            end
            if (z < 0) z = 0;
            if (z > 26353589) z = 26353589;
         end

         mag = (out_variance * longint'(z) + (64'd1 << 23)) >> 24;
         r.kernel = (nmag == 0) ? 32'd0 : (neg ? -mag[31:0] : mag[31:0]);
         r.clamped = clamped;
         r.saturated = sat_seen;
         pending_kernels.push_back(r);
         dot_sum = 0;
         norm_x_sum = 0;
         norm_y_sum = 0;
         sat_seen = 0;
      endfunction

      function void check_kernel(logic [31:0] kv, logic clamped, logic saturated);
         kernel_result_type e;
         if (pending_kernels.size() == 0) begin
            $error("kernel result with none expected: %0d", $signed(kv));
            errors++;
            return;
         end
         e = pending_kernels.pop_front();
         if (kv !== e.kernel) begin
            $error("kernel_value expected %0d got %0d", $signed(e.kernel), $signed(kv));
            errors++;
         end
         if (clamped !== e.clamped) begin
            $error("arg_clamped expected %0d got %0d", e.clamped, clamped);
            errors++;
         end
         if (saturated !== e.saturated) begin
            $error("acc_saturated expected %0d got %0d", e.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_x_component = '0;
   logic signed [15:0] req_y_component = '0;
   logic req_last_component = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_kernel_value;
   logic rsp_arg_clamped;
   logic rsp_acc_saturated;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   kernel_scoreboard kernels = new();
   int sender_idle_pct = 37;   // chance of a gap before each word
   int receiver_idle_pct = 65; // chance of holding ready low in a cycle
   int words_sent = 0;

   always #2 clock = ~clock;

   arcsine_kernel_pair_eval dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_component    (req_x_component),
      .req_y_component    (req_y_component),
      .req_last_component (req_last_component),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kernel_value   (rsp_kernel_value),
      .rsp_arg_clamped    (rsp_arg_clamped),
      .rsp_acc_saturated  (rsp_acc_saturated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // receiver: random back-pressure, check each kernel word taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         kernels.check_kernel(rsp_kernel_value, rsp_arg_clamped, rsp_acc_saturated);
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_idle_pct);
   end

   // one coordinate word, with an optional gap in front of it
   task automatic send_word(logic signed [15:0] xc, logic signed [15:0] yc, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_x_component <= xc;
      req_y_component <= yc;
      req_last_component <= last;
      do @(posedge clock); while (!req_ready);
      kernels.note_word(xc, yc, last);
      words_sent++;
   endtask

   // mix of extremes, small and full-range values
   function automatic logic signed [15:0] pick_component();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return $signed(16'($urandom_range(511))) - 16'sd256;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_pair(int len);
      for (int i = 0; i < len; i++)
         send_word(pick_component(), pick_component(), i == len - 1);
   endtask

   task automatic send_random_pairs(int until_words);
      while (words_sent < until_words)
         send_pair(($urandom_range(9) == 0) ? int'($urandom_range(80, 60))
                                           : int'($urandom_range(8, 1)));
   endtask

   // hold the sender until every kernel has come back and the back end is quiet
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (kernels.pending_kernels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      kernels.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic set_regs(logic [23:0] w, logic [23:0] b, logic [23:0] v);
      write_csr(akpe_pkg::REG_WEIGHT, w);
      write_csr(akpe_pkg::REG_BIAS, b);
      write_csr(akpe_pkg::REG_VAR, v);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes on the reset setting
      send_word(16'sh7FFF, 16'sh7FFF, 1);
      send_word(16'sh8000, 16'sh8000, 1);
      send_word(16'sh8000, 16'sh7FFF, 1);
      send_word(16'sh0000, 16'sh0000, 1);
      send_word(16'sh0001, -16'sh0001, 0);
      send_word(-16'sh0001, 16'sh0001, 1);
      send_word(16'sh1000, -16'sh2000, 0);
      send_word(16'sh1000, -16'sh2000, 0);
      send_word(-16'sh3000, 16'sh0800, 1);
      send_word(16'sh5555, 16'shAAAA, 0);
      send_word(16'shAAAA, 16'sh5555, 1);
      drain();

      // zero bias, full weight and variance; zero numerator shows up here
      set_regs(CFG_MAX, 24'd0, CFG_MAX);
      write_csr(REG_UNUSED, 24'h123456);
      send_word(16'sh0000, 16'sh0005, 1);
      send_word(16'sh7FFF, 16'sh8000, 1);
      send_word(16'sh8000, 16'sh8000, 1);
      send_word(16'sh0001, 16'sh0001, 0);
      send_word(16'sh0003, -16'sh0003, 1);
      send_word(16'sh0100, 16'sh0100, 1);
      drain();

      // random, sender idles less than the receiver
      set_regs(24'($urandom), 24'($urandom), 24'($urandom));
      send_random_pairs(300);
      drain();

      // no weight, full bias, no variance for a while, then random settings
      sender_idle_pct = 65;
      receiver_idle_pct = 37;
      set_regs(24'd0, CFG_MAX, 24'd0);
      send_random_pairs(340);
      drain();
      set_regs(24'($urandom), 24'($urandom_range(4096)), 24'($urandom));
      send_random_pairs(580);
      drain();

      // no idling: one very long pair drives every accumulator into saturation
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_regs(akpe_pkg::CFG_ONE, 24'd0, CFG_MAX);
      for (int i = 0; i < 1030; i++)
         send_word(16'sh8000, 16'sh7FFF, i == 1029);
      send_random_pairs(1700);
      drain();

      if (kernels.errors == 0)
         $display("arcsine_kernel_pair_eval test passed");
      else
         $display("arcsine_kernel_pair_eval test failed");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #40ms;
      $display("arcsine_kernel_pair_eval test failed");
      $finish;
   end

endmodule

[arcsine_kernel_pair_eval.f]
rtl/akpe_pkg.sv
rtl/akpe_front.sv
rtl/akpe_queue.sv
rtl/akpe_back.sv
rtl/arcsine_kernel_pair_eval.sv
dv/arcsine_kernel_pair_eval_tb.sv
